[hw/rtl/shd_pkg.sv]
// Shared constants and types for the sync-hunt frame deframer.
package shd_pkg;

  localparam int unsigned SyncLen       = 4;
  localparam int unsigned PayloadKeep   = 8;
  localparam int unsigned FrameBytesDef = 12;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned WordW         = 32;
  localparam int unsigned TallyW        = 16;
  localparam int unsigned AddW          = 3;

  localparam logic [ByteW-1:0] SyncByte0 = 8'h00;
  localparam logic [ByteW-1:0] SyncByte1 = 8'hAC;
  localparam logic [ByteW-1:0] SyncByte2 = 8'hDD;
  localparam logic [ByteW-1:0] SyncByte3 = 8'hDD;

  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  // hunt progress: number of sync bytes matched, then frame collection
  typedef enum logic [4:0] {
    StMatch0  = 5'b00001,
    StMatch1  = 5'b00010,
    StMatch2  = 5'b00100,
    StMatch3  = 5'b01000,
    StCollect = 5'b10000
  } hunt_state_e;

  typedef struct packed {
    logic signed [WordW-1:0] rotor_position;
    logic        [WordW-1:0] encoder_count;
    logic        [TallyW-1:0] discarded_bytes;
  } result_t;

endpackage

[hw/rtl/shd_in_stage.sv]
// Input register: holds one received byte until the core consumes it.
module shd_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [shd_pkg::ByteW-1:0] rx_byte_i,
  input  logic                     consume_i,
  output logic                     valid_o,
  output logic [shd_pkg::ByteW-1:0] byte_o
);
  import shd_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || consume_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

[hw/rtl/shd_core.sv]
// Sync hunter, discard tally and payload assembly; one byte per step.
module shd_core #(
  parameter int unsigned FRAME_BYTES = shd_pkg::FrameBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [shd_pkg::ByteW-1:0] byte_i,
  output logic                      last_beat_o,
  output shd_pkg::result_t          res_o
);
  import shd_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [IdxW-1:0] IdxFirst = IdxW'(SyncLen);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(FRAME_BYTES - 1);
  localparam logic [IdxW-1:0] IdxKeep  = IdxW'(SyncLen + PayloadKeep);

  hunt_state_e       state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic [ByteW-1:0]  lane_q [PayloadKeep];
  logic [IdxW-1:0]   lane_off;
  logic [2:0]        lane_sel;
  logic              lane_we;
  logic [AddW-1:0]   add_amt;
  logic              add_en;
  logic [TallyW:0]   tally_sum;
  logic [TallyW-1:0] tally_sat;
  logic              is_zero;

  assign is_zero     = (byte_i == SyncByte0);
  assign last_beat_o = (state_q == StCollect) && (idx_q == IdxLast);
  assign lane_off    = idx_q - IdxFirst;
  assign lane_sel    = lane_off[2:0];
  assign lane_we     = step_i && (state_q == StCollect) && (idx_q < IdxKeep);

  assign tally_sum = {1'b0, tally_q} + (TallyW + 1)'(add_amt);
  assign tally_sat = tally_sum[TallyW] ? TallyMax : tally_sum[TallyW-1:0];

  // partial match lost: matched bytes are discarded, and the new byte too
  // unless it can open a fresh sync
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    add_amt = '0;
    add_en  = 1'b0;
    unique case (state_q)
      StMatch0: begin
        if (is_zero) begin
          state_d = StMatch1;
        end else begin
          add_en  = 1'b1;
          add_amt = AddW'(1);
        end
      end
      StMatch1: begin
        if (byte_i == SyncByte1) begin
          state_d = StMatch2;
        end else begin
          add_en  = 1'b1;
          add_amt = is_zero ? AddW'(1) : AddW'(2);
          state_d = is_zero ? StMatch1 : StMatch0;
        end
      end
      StMatch2: begin
        if (byte_i == SyncByte2) begin
          state_d = StMatch3;
        end else begin
          add_en  = 1'b1;
          add_amt = is_zero ? AddW'(2) : AddW'(3);
          state_d = is_zero ? StMatch1 : StMatch0;
        end
      end
      StMatch3: begin
        if (byte_i == SyncByte3) begin
          state_d = StCollect;
          idx_d   = IdxFirst;
        end else begin
          add_en  = 1'b1;
          add_amt = is_zero ? AddW'(3) : AddW'(4);
          state_d = is_zero ? StMatch1 : StMatch0;
        end
      end
      StCollect: begin
        if (idx_q == IdxLast) begin
          state_d = StMatch0;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: begin
        state_d = StMatch0;
        idx_d   = '0;
      end
    endcase
  end

  always_comb begin
    tally_d = tally_q;
    if (add_en) begin
      tally_d = tally_sat;
    end else if (last_beat_o) begin
      tally_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StMatch0;
      idx_q   <= '0;
      tally_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      tally_q <= tally_d;
    end
  end

  // every lane is rewritten before frame end, so no clear at sync
  always_ff @(posedge clk_i) begin
    if (lane_we) begin
      lane_q[lane_sel] <= byte_i;
    end
  end

  // last frame byte never lands in a kept lane when the frame is longer
  // than twelve bytes; for exactly twelve it is lane seven, bypassed here
  always_comb begin
    logic [ByteW-1:0] top_lane;
    top_lane = (lane_we && (lane_sel == 3'd7)) ? byte_i : lane_q[7];
    res_o.rotor_position  = {lane_q[3], lane_q[2], lane_q[1], lane_q[0]};
    res_o.encoder_count   = {top_lane, lane_q[6], lane_q[5], lane_q[4]};
    res_o.discarded_bytes = tally_q;
  end

endmodule

[hw/rtl/sync_hunt_frame_deframer.sv]
// Top level of the sync-hunt frame deframer: input register, core, result register.
//
//   channel  | handshake              | beat contents
//   ---------+------------------------+-----------------------------------------
//   in       | in_valid_i/in_ready_o  | rx_byte_i
//   out      | out_valid_o/out_ready_i| rotor_position_o, encoder_count_o,
//            |                        | discarded_bytes_o
//
// One byte per cycle sustained, except while a frame-ending byte is stalled. A
// beat is registered in the input register and then processed by the core; a
// frame's result is valid the cycle after its last byte is processed.
// Reset clears the hunt state, frame index, discard tally and both valid flags.
// Only the last byte of a frame waits in the input register, and only while
// the result register still holds an untaken result; other bytes flow on.
module sync_hunt_frame_deframer #(
  parameter int unsigned FRAME_BYTES = shd_pkg::FrameBytesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [shd_pkg::ByteW-1:0]         rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [shd_pkg::WordW-1:0]  rotor_position_o,
  output logic [shd_pkg::WordW-1:0]         encoder_count_o,
  output logic [shd_pkg::TallyW-1:0]        discarded_bytes_o
);
  import shd_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] byte_held;
  logic             last_beat;
  logic             stall;
  logic             advance;
  logic             out_load;
  logic             out_valid_q;
  result_t          res_core;
  result_t          res_q;

  shd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .rx_byte_i (rx_byte_i),
    .consume_i (advance),
    .valid_o   (byte_valid),
    .byte_o    (byte_held)
  );

  shd_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (byte_held),
    .last_beat_o(last_beat),
    .res_o      (res_core)
  );

  // hold back only a frame-ending byte when the result slot is occupied and not being taken
  assign stall    = last_beat && out_valid_q && !out_ready_i;
  assign advance  = byte_valid && !stall;
  assign out_load = advance && last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_core;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign rotor_position_o  = res_q.rotor_position;
  assign encoder_count_o   = res_q.encoder_count;
  assign discarded_bytes_o = res_q.discarded_bytes;

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("result register overwritten while held");

  // after a frame completes the core is back to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !last_beat)
    else $error("core still at frame end after emitting");

  // a byte held back by the core stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid && !advance) |=> (byte_valid && $stable(byte_held)))
    else $error("stalled byte lost from input register");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the sync-hunt frame deframer.
//
// A scoreboard class tracks the hunt state, frame index, payload bytes and
// discard tally as the block should, and predicts one result per completed
// frame. Each accepted output beat is checked against the oldest prediction.
// Stimulus runs in phases:
//   - directed: sync prefixes broken at every depth, a restart on 00, and frames
//     carrying the extreme rotor and encoder words;
//   - random: mostly well-formed frames with noise and broken prefixes between;
//   - backpressure: the sink holds off for a long stretch while frames keep
//     coming, and the source pauses until every result is out;
//   - a closing stretch with no idling on either side.
module testbench;
  import shd_pkg::*;

  localparam int unsigned FrameLen    = FrameBytesDef;
  localparam int unsigned TrailBytes  = FrameLen - SyncLen - PayloadKeep;
  localparam int unsigned RandomBytes = 900;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  // sync pattern, byte k at bits 8k..8k+7
  localparam logic [4*ByteW-1:0] SyncWord = {SyncByte3, SyncByte2, SyncByte1, SyncByte0};

  // Predicts frame results from accepted bytes and checks the output beats.
  class frame_scoreboard;
    logic [2:0]        hunt_cnt;
    logic [6:0]        frame_idx;
    logic [63:0]       payload;
    logic [TallyW-1:0] tally;
    result_t           frames_due[$];
    int unsigned       errors;
    int unsigned       bytes_seen;
    int unsigned       frames_checked;

    function new();
      hunt_cnt  = '0;
      frame_idx = '0;
      payload   = '0;
      tally     = '0;
    endfunction

    function void add_discards(int unsigned n);
      int unsigned sum;
      sum   = int'(tally) + n;
      tally = (sum > int'(TallyMax)) ? TallyMax : sum[TallyW-1:0];
    endfunction

    // one accepted input beat
    function void take_byte(logic [ByteW-1:0] b);
      int unsigned slot;
      result_t     r;
      bytes_seen++;
      if (hunt_cnt < SyncLen) begin
        if (b == SyncWord[8*hunt_cnt +: 8]) begin
          hunt_cnt++;
          if (hunt_cnt == SyncLen) begin
            frame_idx = 7'(SyncLen);
            payload   = '0;
          end
        end else begin
          // matched prefix is lost; the odd byte may start a new hunt
          add_discards(32'(hunt_cnt));
          if (b == SyncByte0) begin
            hunt_cnt = 3'd1;
          end else begin
            add_discards(1);
            hunt_cnt = '0;
          end
        end
      end else begin
        slot = frame_idx - SyncLen;
        if (slot < PayloadKeep) payload[8*slot +: 8] = b;
        frame_idx = frame_idx + 7'd1;
        if (frame_idx >= FrameLen) begin
          r.rotor_position  = payload[31:0];
          r.encoder_count   = payload[63:32];
          r.discarded_bytes = tally;
          frames_due.push_back(r);
          tally     = '0;
          hunt_cnt  = '0;
          frame_idx = '0;
          payload   = '0;
        end
      end
    endfunction

    // one accepted output beat
    function void check_frame(logic signed [WordW-1:0] rotor, logic [WordW-1:0] enc,
                              logic [TallyW-1:0] disc);
      result_t e;
      if (frames_due.size() == 0) begin
        $display("%0t unexpected result: rotor %0d encoder %0d discarded %0d",
                 $time, rotor, enc, disc);
        errors++;
        return;
      end
      e = frames_due.pop_front();
      frames_checked++;
      if (rotor !== e.rotor_position) begin
        $display("%0t rotor_position mismatch: expected %0d, got %0d",
                 $time, e.rotor_position, rotor);
        errors++;
      end
      if (enc !== e.encoder_count) begin
        $display("%0t encoder_count mismatch: expected %0d, got %0d",
                 $time, e.encoder_count, enc);
        errors++;
      end
      if (disc !== e.discarded_bytes) begin
        $display("%0t discarded_bytes mismatch: expected %0d, got %0d",
                 $time, e.discarded_bytes, disc);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [ByteW-1:0]         rx_byte = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WordW-1:0]  rotor_position;
  logic [WordW-1:0]         encoder_count;
  logic [TallyW-1:0]        discarded_bytes;

  frame_scoreboard sb;

  // idling switches, and the sink's long hold-off request
  bit          source_idles = 1'b1;
  bit          sink_idles   = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned idle_cycles  = 0;

  sync_hunt_frame_deframer #(
    .FRAME_BYTES(FrameLen)
  ) DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .rotor_position_o (rotor_position),
    .encoder_count_o  (encoder_count),
    .discarded_bytes_o(discarded_bytes)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sink: a long hold-off when asked for one, else short random stalls.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LongHold;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_idles && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Both channels are sampled here. The output beat is checked before the
  // input beat is noted: a byte taken at this edge cannot finish a frame yet.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_frame(rotor_position, encoder_count, discarded_bytes);
      if (in_valid && in_ready) sb.take_byte(rx_byte);
    end
  end

  // Watchdog: ends the run once no beat has moved for too long.
  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat accepted for %0d cycles", StallLimit);
    $display("FAIL sync_hunt_frame_deframer");
    $finish;
  end

  // Offer one byte, maybe after a short gap, and hold it until it is taken.
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (source_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_sync();
    for (int k = 0; k < SyncLen; k++) send_byte(SyncWord[8*k +: 8]);
  endtask

  // complete frame: sync, both words little-endian, then random filler
  task automatic send_frame(input logic [WordW-1:0] rotor, input logic [WordW-1:0] enc);
    send_sync();
    for (int k = 0; k < 4; k++) send_byte(rotor[8*k +: 8]);
    for (int k = 0; k < 4; k++) send_byte(enc[8*k +: 8]);
    for (int k = 0; k < TrailBytes; k++) send_byte(ByteW'($urandom_range(0, 255)));
  endtask

  // a sync prefix of 1 to 3 bytes cut off by a wrong byte (00 included)
  task automatic send_broken_sync();
    int unsigned depth;
    logic [ByteW-1:0] odd;
    depth = $urandom_range(1, SyncLen - 1);
    for (int k = 0; k < depth; k++) send_byte(SyncWord[8*k +: 8]);
    do odd = ($urandom_range(0, 2) == 0) ? SyncByte0 : ByteW'($urandom_range(0, 255));
    while (odd == SyncWord[8*depth +: 8]);
    send_byte(odd);
  endtask

  // noise leaning towards the sync byte values
  task automatic send_noise(input int unsigned n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0:       send_byte(SyncByte0);
        1:       send_byte(SyncByte1);
        2:       send_byte(SyncByte2);
        default: send_byte(ByteW'($urandom_range(0, 255)));
      endcase
    end
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // stop offering until every predicted result has left the block
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic random_traffic(input int unsigned nbytes);
    int unsigned stop_at;
    stop_at = sb.bytes_seen + nbytes;
    while (sb.bytes_seen < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1:    send_noise($urandom_range(1, 6));
        2:       send_broken_sync();
        default: begin
          if ($urandom_range(0, 1) == 0) send_noise($urandom_range(0, 3));
          if ($urandom_range(0, 3) == 0) send_broken_sync();
          send_frame(pick_word(), pick_word());
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: prefix broken at depth 3 by 00, which restarts the hunt,
    // then a frame with the most negative rotor word and an all-ones count.
    send_byte(SyncByte0); send_byte(SyncByte1); send_byte(SyncByte2);
    send_byte(SyncByte0);
    send_byte(SyncByte1); send_byte(SyncByte2); send_byte(SyncByte3);
    for (int k = 0; k < 4; k++) send_byte(k == 3 ? 8'h80 : 8'h00);
    for (int k = 0; k < 4; k++) send_byte(8'hFF);
    for (int k = 0; k < TrailBytes; k++) send_byte(8'h5A);
    // depth 2 broken by a non-sync byte, plain noise, 00 repeated at depth 1,
    // then a frame with the largest rotor word and a zero count
    send_byte(SyncByte0); send_byte(SyncByte1); send_byte(8'h5A);
    send_byte(8'hFF);
    send_byte(SyncByte0);
    send_frame(32'h7FFF_FFFF, 32'h0000_0000);
    wait_drained();

    random_traffic(RandomBytes / 3);

    // Sink holds off while frames keep coming, so the block backs up.
    wait_drained();
    source_idles = 1'b0;
    hold_request = 1'b1;
    for (int k = 0; k < 4; k++) send_frame(pick_word(), pick_word());
    source_idles = 1'b1;
    wait_drained();

    random_traffic(RandomBytes / 2);

    // closing stretch at full rate on both sides
    source_idles = 1'b0;
    sink_idles   = 1'b0;
    random_traffic(RandomBytes / 6);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0d predicted results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Run covered %0d input bytes and %0d checked frames,",
             sb.bytes_seen, sb.frames_checked);
    $display("broken sync prefixes at every depth, sink backpressure and a full-rate finish.");
    if (sb.errors == 0) begin
      $display("PASS sync_hunt_frame_deframer");
    end else begin
      $display("FAIL sync_hunt_frame_deframer");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/shd_pkg.sv
hw/rtl/shd_in_stage.sv
hw/rtl/shd_core.sv
hw/rtl/sync_hunt_frame_deframer.sv
sim/testbench.sv
